/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL. Every macro samples on aclk and is
// disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define VTDI_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define VTDI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define VTDI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/vtdi_pkg.sv */
`default_nettype none

package vtdi_pkg;

    localparam int DIR_W = 9;
    localparam int QUO_W = 9;
    localparam int ANG_W = 10;
    localparam int ATN_W = 7;

    // Pipeline layout: octant stage, one stage per quotient bit, three
    // polynomial stages, scaling and the output register.
    localparam int STG_OCT = 0;
    localparam int STG_DIV_LAST = STG_OCT + QUO_W;
    localparam int STG_SQR = STG_DIV_LAST + 1;
    localparam int STG_CUB = STG_SQR + 1;
    localparam int STG_ANG = STG_CUB + 1;
    localparam int STG_SCL = STG_ANG + 1;
    localparam int STG_OUT = STG_SCL + 1;
    localparam int NSTG = STG_OUT + 1;

    localparam logic [ANG_W-1:0] ANG_0 = 10'd0;
    localparam logic [ANG_W-1:0] ANG_128 = 10'd128;
    localparam logic [ANG_W-1:0] ANG_256 = 10'd256;
    localparam logic [ANG_W-1:0] ANG_384 = 10'd384;
    localparam logic [ANG_W-1:0] ANG_512 = 10'd512;

    localparam logic [6:0] COEF_LIN = 7'd82;
    localparam logic [5:0] COEF_SQR = 6'd62;
    localparam logic [3:0] COEF_CUB = 4'd10;
    localparam int SHIFT_LIN = 8;
    localparam int SHIFT_SQR = 19;
    localparam int SHIFT_CUB = 24;

    localparam logic [8:0] ROUND_HALF = 9'd256;
    localparam int SCALE_SHIFT = 9;
    localparam logic [DIR_W-1:0] DIR_COUNT_RST = 9'd16;
    localparam logic [DIR_W-1:0] DIR_NONE = 9'd0;
    localparam logic [DIR_W-1:0] DIR_FIRST = 9'd1;
    localparam logic [QUO_W-1:0] QUO_MAX = 9'd256;

    typedef struct packed {
        logic             zero;
        logic             neg;
        logic [ANG_W-1:0] base;
    } side_t;

endpackage

`default_nettype wire

/* hdl/vtdi_div_step.sv */
`default_nettype none

module vtdi_div_step #(
    parameter int VELOCITY_WIDTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [VELOCITY_WIDTH:0]     rem_in,
    input  wire logic [VELOCITY_WIDTH-1:0]   den_in,
    input  wire logic [vtdi_pkg::QUO_W-1:0]  quo_in,
    input  wire vtdi_pkg::side_t             side_in,
    output logic      [VELOCITY_WIDTH-1:0]   rem_out,
    output logic      [VELOCITY_WIDTH-1:0]   den_out,
    output logic      [vtdi_pkg::QUO_W-1:0]  quo_out,
    output vtdi_pkg::side_t                  side_out
);
    import vtdi_pkg::*;

    logic [VELOCITY_WIDTH:0]   den_ext;
    logic [VELOCITY_WIDTH:0]   diff;
    logic                      take;
    logic [VELOCITY_WIDTH-1:0] rem_next;

    // One restoring step: the partial remainder stays below the divisor.
    always_comb begin
        den_ext = {1'b0, den_in};
        diff = rem_in - den_ext;
        take = (rem_in >= den_ext);
        rem_next = take ? diff[VELOCITY_WIDTH-1:0] : rem_in[VELOCITY_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out <= rem_next;
            den_out <= den_in;
            quo_out <= {quo_in[QUO_W-2:0], take};
            side_out <= side_in;
        end
    end

endmodule

`default_nettype wire

/* hdl/vector_to_direction_index.sv */
// Throughput: one vector per cycle while s_ready is high. The pipeline has octant
// selection, nine restoring divider stages (one quotient bit each), three
// polynomial stages, a scaling multiply and the output register. A stalled
// output only holds stages that are full; empty stages keep accepting.
// Synchronous reset empties the pipeline and sets direction_count to 16.
`default_nettype none

`include "assert_macros.svh"

module vector_to_direction_index #(
    parameter int VELOCITY_WIDTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vtdi_pkg::DIR_W-1:0]        cfg_direction_count,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [VELOCITY_WIDTH-1:0]  s_vel_x,
    input  wire logic signed [VELOCITY_WIDTH-1:0]  s_vel_y,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [vtdi_pkg::DIR_W-1:0]        m_direction
);
    import vtdi_pkg::*;

    localparam int W = VELOCITY_WIDTH;

    logic [DIR_W-1:0] dir_count_reg;

    logic [NSTG-1:0] stg_vld_reg;
    logic [NSTG-1:0] stg_vld_next;
    logic [NSTG-1:0] stg_en;

    // Octant stage.
    logic [W-1:0] mag_x;
    logic [W-1:0] mag_y;
    logic [W-1:0] num_next;
    logic [W-1:0] den_next;
    side_t        side_next;
    logic [W-1:0] num0_reg;
    logic [W-1:0] den0_reg;
    side_t        side0_reg;

    // Divider chain, index 0 is the octant stage.
    logic [W-1:0]     div_rem  [0:QUO_W];
    logic [W-1:0]     div_den  [0:QUO_W];
    logic [QUO_W-1:0] div_quo  [0:QUO_W];
    side_t            div_side [0:QUO_W];

    // Polynomial stages.
    logic [15:0]      lin_prod;
    logic [17:0]      sqr_full;
    logic [QUO_W-1:0] q_reg;
    logic [16:0]      q2_reg;
    logic [ATN_W-1:0] t1_reg;
    side_t            side_sqr_reg;

    logic [25:0]      cub_full;
    logic [22:0]      sqr_prod;
    logic [24:0]      q3_reg;
    logic [2:0]       t2_reg;
    logic [ATN_W-1:0] t1b_reg;
    side_t            side_cub_reg;

    logic [28:0]      cub_prod;
    logic [ATN_W-1:0] atn;
    logic [ANG_W-1:0] ang_next;
    logic [ANG_W-1:0] ang_reg;
    logic             zero_ang_reg;

    logic [18:0]      scl_sum;
    logic [ANG_W-1:0] d_reg;
    logic             zero_scl_reg;

    logic [DIR_W-1:0] dir_next;
    logic [DIR_W-1:0] dir_reg;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_count_reg <= DIR_COUNT_RST;
        end else if (cfg_valid) begin
            dir_count_reg <= cfg_direction_count;
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stg_en[NSTG-1] = !stg_vld_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !stg_vld_reg[k] || stg_en[k+1];
        end
        for (int k = 0; k < NSTG; k++) begin
            if (stg_en[k]) begin
                stg_vld_next[k] = (k == 0) ? s_valid : stg_vld_reg[(k == 0) ? 0 : k - 1];
            end else begin
                stg_vld_next[k] = stg_vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= '0;
        end else begin
            stg_vld_reg <= stg_vld_next;
        end
    end

    assign s_ready = stg_en[STG_OCT];
    assign m_valid = stg_vld_reg[STG_OUT];
    assign m_direction = dir_reg;

    // Octant selection: the smaller magnitude is divided by the larger one.
    always_comb begin
        mag_x = s_vel_x[W-1] ? (~s_vel_x + 1'b1) : s_vel_x;
        mag_y = s_vel_y[W-1] ? (~s_vel_y + 1'b1) : s_vel_y;
        side_next.zero = 1'b0;
        side_next.neg = 1'b0;
        side_next.base = ANG_0;
        num_next = mag_x;
        den_next = mag_y;
        priority if (s_vel_x == '0 && s_vel_y == '0) begin
            side_next.zero = 1'b1;
        end else if (!s_vel_x[W-1] && s_vel_x != '0) begin
            if (s_vel_y[W-1]) begin
                if (mag_y > mag_x) begin
                    side_next.base = ANG_0;
                end else begin
                    num_next = mag_y;
                    den_next = mag_x;
                    side_next.base = ANG_128;
                    side_next.neg = 1'b1;
                end
            end else begin
                if (mag_x > mag_y) begin
                    num_next = mag_y;
                    den_next = mag_x;
                    side_next.base = ANG_128;
                end else begin
                    side_next.base = ANG_256;
                    side_next.neg = 1'b1;
                end
            end
        end else begin
            if (!s_vel_y[W-1] && s_vel_y != '0) begin
                if (mag_y > mag_x) begin
                    side_next.base = ANG_256;
                end else begin
                    num_next = mag_y;
                    den_next = mag_x;
                    side_next.base = ANG_384;
                    side_next.neg = 1'b1;
                end
            end else begin
                if (mag_x > mag_y) begin
                    num_next = mag_y;
                    den_next = mag_x;
                    side_next.base = ANG_384;
                end else begin
                    side_next.base = ANG_512;
                    side_next.neg = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[STG_OCT]) begin
            num0_reg <= num_next;
            den0_reg <= den_next;
            side0_reg <= side_next;
        end
    end

    assign div_rem[0] = num0_reg;
    assign div_den[0] = den0_reg;
    assign div_quo[0] = '0;
    assign div_side[0] = side0_reg;

    // The first step finds the top quotient bit without a shift, since the
    // minor magnitude never exceeds the major one.
    for (genvar i = 0; i < QUO_W; i++) begin : g_div
        logic [W:0] rem_in;
        if (i == 0) begin : g_first
            assign rem_in = {1'b0, div_rem[i]};
        end else begin : g_rest
            assign rem_in = {div_rem[i], 1'b0};
        end
        vtdi_div_step #(
            .VELOCITY_WIDTH(VELOCITY_WIDTH)
        ) u_step (
            .aclk     (aclk),
            .en       (stg_en[STG_OCT + 1 + i]),
            .rem_in   (rem_in),
            .den_in   (div_den[i]),
            .quo_in   (div_quo[i]),
            .side_in  (div_side[i]),
            .rem_out  (div_rem[i+1]),
            .den_out  (div_den[i+1]),
            .quo_out  (div_quo[i+1]),
            .side_out (div_side[i+1])
        );
    end

    // Square and linear term.
    always_comb begin
        lin_prod = 16'(div_quo[QUO_W]) * 16'(COEF_LIN);
        sqr_full = 18'(div_quo[QUO_W]) * 18'(div_quo[QUO_W]);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[STG_SQR]) begin
            q_reg <= div_quo[QUO_W];
            q2_reg <= sqr_full[16:0];
            t1_reg <= lin_prod[SHIFT_LIN +: ATN_W];
            side_sqr_reg <= div_side[QUO_W];
        end
    end

    // Cube and square term.
    always_comb begin
        cub_full = 26'(q2_reg) * 26'(q_reg);
        sqr_prod = 23'(q2_reg) * 23'(COEF_SQR);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[STG_CUB]) begin
            q3_reg <= cub_full[24:0];
            t2_reg <= sqr_prod[SHIFT_SQR +: 3];
            t1b_reg <= t1_reg;
            side_cub_reg <= side_sqr_reg;
        end
    end

    // Cubic term, arctangent and octant offset.
    always_comb begin
        cub_prod = 29'(q3_reg) * 29'(COEF_CUB);
        atn = t1b_reg - ATN_W'(t2_reg) - ATN_W'(cub_prod[SHIFT_CUB +: 4]);
        if (side_cub_reg.neg) begin
            ang_next = side_cub_reg.base - ANG_W'(atn);
        end else begin
            ang_next = side_cub_reg.base + ANG_W'(atn);
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[STG_ANG]) begin
            ang_reg <= ang_next;
            zero_ang_reg <= side_cub_reg.zero;
        end
    end

    // Scale the angle to the number of directions with rounding.
    always_comb begin
        scl_sum = 19'(ang_reg) * 19'(dir_count_reg) + 19'(ROUND_HALF);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[STG_SCL]) begin
            d_reg <= scl_sum[SCALE_SHIFT +: ANG_W];
            zero_scl_reg <= zero_ang_reg;
        end
    end

    // A rounded index that reaches the count wraps to the first direction.
    always_comb begin
        priority if (zero_scl_reg) begin
            dir_next = DIR_NONE;
        end else if (d_reg >= {1'b0, dir_count_reg}) begin
            dir_next = DIR_FIRST;
        end else begin
            dir_next = d_reg[DIR_W-1:0] + DIR_FIRST;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[STG_OUT]) begin
            dir_reg <= dir_next;
        end
    end

    `VTDI_ASSERT_NXT(a_accept_fills_first, s_valid && s_ready, stg_vld_reg[STG_OCT], "accepted transaction did not enter the pipeline")
    `VTDI_ASSERT_IMP(a_div_rem_below_den, stg_vld_reg[STG_DIV_LAST] && !div_side[QUO_W].zero, div_rem[QUO_W] < div_den[QUO_W], "divider remainder not below divisor")
    `VTDI_ASSERT_IMP(a_quo_range, stg_vld_reg[STG_DIV_LAST] && !div_side[QUO_W].zero, div_quo[QUO_W] <= QUO_MAX, "ratio exceeds one")
    `VTDI_ASSERT_IMP(a_ang_range, stg_vld_reg[STG_ANG], ang_reg <= ANG_512, "angle beyond full circle")

endmodule

`default_nettype wire

/* dv/heading_checker.sv */
module heading_checker #(
    parameter int VELOCITY_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [vtdi_pkg::DIR_W-1:0]          cfg_direction_count,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [VELOCITY_WIDTH-1:0]    s_vel_x,
    input  logic signed [VELOCITY_WIDTH-1:0]    s_vel_y,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [vtdi_pkg::DIR_W-1:0]          m_direction,
    output int                                  fail_count,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import vtdi_pkg::*;

    localparam int PRINT_CAP = 50;

    typedef struct {
        logic signed [VELOCITY_WIDTH-1:0] vx;
        logic signed [VELOCITY_WIDTH-1:0] vy;
        logic [DIR_W-1:0]                 count;
        logic [DIR_W-1:0]                 direction;
    } heading_t;

    heading_t         pending_headings[$];
    heading_t         accepted_vec;
    heading_t         oldest_vec;
    logic [DIR_W-1:0] dir_count_model = DIR_COUNT_RST;
    int               mismatches = 0;

    assign fail_count = mismatches;
    initial outstanding = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // atan(minor/major) for minor <= major, scaled to 512 per full circle, via
    // the cubic fit on a fixed-point ratio with 8 fractional bits.
    function automatic longint octant_arc(input longint minor, input longint major);
        longint q;
        q = (minor * 256) / major;
        return ((82 * q) >>> 8) - ((62 * q * q) >>> 19) - ((10 * q * q * q) >>> 24);
    endfunction

    function automatic logic [DIR_W-1:0] heading_index(
        input logic signed [VELOCITY_WIDTH-1:0] vx,
        input logic signed [VELOCITY_WIDTH-1:0] vy,
        input logic [DIR_W-1:0]                 count
    );
        longint x, y, ax, ay, ang, n, d, res;
        x = vx;
        y = vy;
        n = count;
        if (x == 0 && y == 0)
            return DIR_NONE;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        // Angle runs clockwise from straight up, 512 for the full circle.
        // A tie on a diagonal takes the second form in each quadrant.
        if (x > 0) begin
            if (y < 0)
                ang = (ay > x) ? octant_arc(x, ay) : 128 - octant_arc(ay, x);
            else
                ang = (x > y) ? 128 + octant_arc(y, x) : 256 - octant_arc(x, y);
        end else begin
            if (y > 0)
                ang = (y > ax) ? 256 + octant_arc(ax, y) : 384 - octant_arc(y, ax);
            else
                ang = (ax > ay) ? 384 + octant_arc(ay, ax) : 512 - octant_arc(ax, ay);
        end
        d = (ang * n + 256) >>> 9;
        res = (d > n - 1) ? 1 : d + 1;
        return res[DIR_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_headings.delete();
            dir_count_model = DIR_COUNT_RST;
        end else begin
            if (cfg_valid && cfg_ready)
                dir_count_model = cfg_direction_count;
            if (s_valid && s_ready) begin
                accepted_vec.vx = s_vel_x;
                accepted_vec.vy = s_vel_y;
                accepted_vec.count = dir_count_model;
                accepted_vec.direction = heading_index(s_vel_x, s_vel_y, dir_count_model);
                pending_headings.push_back(accepted_vec);
            end
            if (m_valid && m_ready) begin
                if (pending_headings.size() == 0) begin
                    report_mismatch($sformatf("direction %0d with no vector pending",
                                              m_direction));
                end else begin
                    oldest_vec = pending_headings.pop_front();
                    if (m_direction !== oldest_vec.direction)
                        report_mismatch($sformatf(
                            "vector (%0d,%0d) count %0d: direction %0d, predicted %0d",
                            oldest_vec.vx, oldest_vec.vy, oldest_vec.count,
                            m_direction, oldest_vec.direction));
                end
            end
        end
        outstanding <= pending_headings.size();
    end

endmodule

/* dv/tb_vector_to_direction_index.sv */
module tb_vector_to_direction_index;
    timeunit 1ns;
    timeprecision 1ps;

    import vtdi_pkg::*;

    localparam int VW = 16;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 8;
    localparam int PHASE_VECTORS = 140;
    localparam int DIRECTED_N = 23;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [DIR_W-1:0]     cfg_direction_count = DIR_COUNT_RST;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [VW-1:0] s_vel_x = '0;
    logic signed [VW-1:0] s_vel_y = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [DIR_W-1:0]     m_direction;

    int       fail_count;
    int       outstanding;
    int       cycle_count = 0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_left = 0;
    int       rx_step = 0;

    // Axes, extreme magnitudes, the most negative value and diagonal ties.
    int directed_x [DIRECTED_N] = '{0, 0, 1, 0, -1, 32767, -32768, 0, 0, -32768, 32767,
                                    32767, -32768, 100, 100, -100, -100, 3, 5, -32767,
                                    1, -1, 32767};
    int directed_y [DIRECTED_N] = '{0, -1, 0, 1, 0, 0, 0, 32767, -32768, -32768, 32767,
                                    -32768, 32767, -100, 100, 100, -100, -5, -3, 1,
                                    -32767, -32768, 1};

    always #10 aclk = ~aclk;

    vector_to_direction_index #(
        .VELOCITY_WIDTH(VW)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_direction_count (cfg_direction_count),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_vel_x             (s_vel_x),
        .s_vel_y             (s_vel_y),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_direction         (m_direction)
    );

    heading_checker #(
        .VELOCITY_WIDTH(VW)
    ) u_heading_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_direction_count (cfg_direction_count),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_vel_x             (s_vel_x),
        .s_vel_y             (s_vel_y),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_direction         (m_direction),
        .fail_count          (fail_count),
        .outstanding         (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The result side changes its stall behavior from time to time, picking one of four modes at random.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_step <= rx_step + 1;
        case (rx_mode)
            RX_ALWAYS:   m_ready <= 1'b1;
            RX_COIN:     m_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
            default:     m_ready <= (rx_step % 5 != 0);
        endcase
    end

    function automatic logic signed [VW-1:0] to_vel(input int v);
        return v[VW-1:0];
    endfunction

    function automatic void pick_vector(output logic signed [VW-1:0] vx,
                                        output logic signed [VW-1:0] vy);
        int extremes [6] = '{-32768, -32767, -1, 0, 1, 32767};
        int kind, mag, delta, a, b;
        kind = $urandom_range(0, 99);
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        if (kind < 35) begin
            vx = to_vel(a);
            vy = to_vel(b);
        end else if (kind < 55) begin
            vx = to_vel(a % 17 - 8);
            vy = to_vel(b % 17 - 8);
        end else if (kind < 70) begin
            // Close to a diagonal, where the octant choice flips.
            mag = $urandom_range(0, 32767) >> $urandom_range(0, 14);
            delta = $urandom_range(0, 4);
            delta = delta - 2;
            vx = to_vel(($urandom_range(0, 1) == 1) ? -mag : mag);
            vy = to_vel(($urandom_range(0, 1) == 1) ? -(mag + delta) : mag + delta);
        end else if (kind < 80) begin
            vx = ($urandom_range(0, 1) == 1) ? to_vel(a) : '0;
            vy = (vx == 0) ? to_vel(b) : '0;
        end else if (kind < 88) begin
            vx = to_vel(extremes[$urandom_range(0, 5)]);
            vy = to_vel(extremes[$urandom_range(0, 5)]);
        end else begin
            a = a - 32768;
            b = b - 32768;
            vx = to_vel(a >>> $urandom_range(0, 15));
            vy = to_vel(b >>> $urandom_range(0, 15));
        end
    endfunction

    // Offers one vector and returns at the edge where it is accepted, then
    // inserts an idle gap when the current burst is used up, unless no_gaps is set.
    task automatic send_vector(input logic signed [VW-1:0] vx,
                               input logic signed [VW-1:0] vy,
                               input bit no_gaps);
        int gap;
        s_vel_x <= vx;
        s_vel_y <= vy;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            if (!no_gaps && gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic write_direction_count(input logic [DIR_W-1:0] value);
        wait_drained();
        cfg_direction_count <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int settings [PHASES];
        logic signed [VW-1:0] vx, vy;
        settings = '{1, 256, 0, 511, 2, 3, 300, 16};
        settings[5] = $urandom_range(3, 255);
        settings[6] = $urandom_range(257, 510);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_vector(to_vel(directed_x[i]), to_vel(directed_y[i]), 1'b0);
        s_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            write_direction_count(settings[p][DIR_W-1:0]);
            for (int k = 0; k < PHASE_VECTORS; k++) begin
                pick_vector(vx, vy);
                send_vector(vx, vy, p % 3 == 1);
            end
            s_valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
